@@ sv/ntppoc_pkg.sv @@
package ntppoc_pkg;

   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_SERVER_ADDR = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_UTC_OFFSET = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_POLL_INTERVAL = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT = 2'd3;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_REPLY = 1'b1;

   localparam int MODE_SERVER_BIT = 2;

   localparam logic [31:0] POLL_INTERVAL_RST = 32'd1024000;
   localparam logic [31:0] TIMEOUT_RST = 32'd3000;

   localparam logic [31:0] EPOCH_GAP = 32'h83aa7e80;
   localparam logic [20:0] ONE_MILLION = 21'd1000000;
   localparam logic [19:0] HALF_MILLION = 20'd500000;

   // micros to binary fraction
   localparam logic [31:0] M2F_MUL_A = 32'd4294;
   localparam logic [31:0] M2F_MUL_B = 32'd1981;
   localparam logic [31:0] M2F_MUL_C = 32'd2911;
   localparam int M2F_SHIFT_B = 11;
   localparam int M2F_SHIFT_C = 28;

   // binary fraction to micros
   localparam logic [22:0] F2U_ROUND = 23'd32768;
   localparam logic [16:0] F2U_MUL = 17'd759;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_WAITING = 2'd1,
      ST_FAILED = 2'd2
   } status_type;

   typedef struct packed {
      logic               opcode;
      logic [31:0]        now_ms;
      logic [31:0]        local_seconds;
      logic [19:0]        local_micros;
      logic               reply_length_ok;
      logic [31:0]        reply_from_addr;
      logic [7:0]         reply_mode_byte;
      logic [31:0]        recv_seconds;
      logic [31:0]        recv_fraction;
      logic [31:0]        xmit_seconds;
      logic [31:0]        xmit_fraction;
   } req_type;

   typedef struct packed {
      logic               send_request;
      logic [31:0]        origin_seconds;
      logic [31:0]        origin_fraction;
      logic               set_clock;
      logic [31:0]        new_seconds;
      logic [19:0]        new_micros;
      logic signed [31:0] offset_seconds;
      logic [19:0]        offset_micros;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic [31:0]        server_addr;
      logic signed [16:0] utc_offset_seconds;
      logic [31:0]        poll_interval_ms;
      logic [31:0]        timeout_ms;
   } cfg_type;

   typedef struct packed {
      logic       send_request;
      logic       set_clock;
      status_type status;
   } ctl_type;

   typedef struct packed {
      ctl_type     ctl;
      logic [31:0] local_seconds;
      logic [19:0] local_micros;
      logic [31:0] org_seconds;
      logic [19:0] org_micros;
      logic [31:0] recv_seconds;
      logic [31:0] recv_fraction;
      logic [31:0] xmit_seconds;
      logic [31:0] xmit_fraction;
   } entry_type;

   function automatic logic [19:0] frac_to_micros(input logic [31:0] f);
      logic [22:0] r;
      logic [16:0] c;
      r = {1'b0, f[31:10]} + F2U_ROUND;
      c = 17'(r[22:16]) * F2U_MUL;
      return f[31:12] - 20'(c);
   endfunction

endpackage

@@ sv/ntppoc_fifo.sv @@
module ntppoc_fifo #(
   parameter int DEPTH = ntppoc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_valid,
   output logic                  wr_ready,
   input  ntppoc_pkg::entry_type wr_data,
   output logic                  rd_valid,
   input  logic                  rd_ready,
   output ntppoc_pkg::entry_type rd_data
);
   import ntppoc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign wr_ready = (count_ff != CNT_W'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

@@ sv/ntppoc_front.sv @@
module ntppoc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  ntppoc_pkg::cfg_type   cfg,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ntppoc_pkg::req_type   req_data,
   output logic                  push_valid,
   input  logic                  push_ready,
   output ntppoc_pkg::entry_type push_entry
);
   import ntppoc_pkg::*;

   status_type  status_ff, status_in;
   logic [31:0] last_poll_ff, last_poll_in;
   logic [31:0] request_ms_ff, request_ms_in;
   logic [31:0] org_sec_ff, org_sec_in;
   logic [19:0] org_us_ff, org_us_in;

   logic accept, enabled, poll_due, got_reply, timed_out;
   logic send_request, set_clock;
   logic [31:0] utc32;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;
   assign utc32      = {{15{cfg.utc_offset_seconds[16]}}, cfg.utc_offset_seconds};

   always_comb begin
      enabled   = (cfg.server_addr != '0);
      poll_due  = ((req_data.now_ms - last_poll_ff) > cfg.poll_interval_ms);
      timed_out = ((req_data.now_ms - request_ms_ff) > cfg.timeout_ms);
      got_reply = (req_data.opcode == OP_REPLY) && req_data.reply_length_ok
                  && (req_data.reply_from_addr == cfg.server_addr);
   end

   // next state
   always_comb begin
      status_in = status_ff;
      if (accept && enabled) begin
         case (status_ff)
            ST_IDLE, ST_FAILED: begin
               if (poll_due) begin
                  status_in = ST_WAITING;
               end
            end
            ST_WAITING: begin
               if (got_reply) begin
                  status_in = ST_IDLE;
               end else if (timed_out) begin
                  status_in = ST_FAILED;
               end
            end
            default: status_in = status_ff;
         endcase
      end
   end

   // outputs
   always_comb begin
      send_request  = 1'b0;
      set_clock     = 1'b0;
      last_poll_in  = last_poll_ff;
      request_ms_in = request_ms_ff;
      org_sec_in    = org_sec_ff;
      org_us_in     = org_us_ff;
      if (accept && enabled) begin
         case (status_ff)
            ST_IDLE, ST_FAILED: begin
               if (poll_due) begin
                  send_request  = 1'b1;
                  request_ms_in = req_data.now_ms;
                  org_sec_in    = req_data.local_seconds - utc32 + EPOCH_GAP;
                  org_us_in     = req_data.local_micros;
               end
            end
            ST_WAITING: begin
               if (got_reply && req_data.reply_mode_byte[MODE_SERVER_BIT]) begin
                  set_clock    = 1'b1;
                  last_poll_in = req_data.now_ms;
               end
            end
            default: send_request = 1'b0;
         endcase
      end
   end

   always_comb begin
      push_entry.ctl.send_request = send_request;
      push_entry.ctl.set_clock    = set_clock;
      push_entry.ctl.status       = status_in;
      push_entry.local_seconds    = req_data.local_seconds;
      push_entry.local_micros     = req_data.local_micros;
      push_entry.org_seconds      = org_sec_ff;
      push_entry.org_micros       = org_us_ff;
      push_entry.recv_seconds     = req_data.recv_seconds;
      push_entry.recv_fraction    = req_data.recv_fraction;
      push_entry.xmit_seconds     = req_data.xmit_seconds;
      push_entry.xmit_fraction    = req_data.xmit_fraction;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff     <= ST_IDLE;
         last_poll_ff  <= '0;
         request_ms_ff <= '0;
         org_sec_ff    <= '0;
         org_us_ff     <= '0;
      end else begin
         status_ff     <= status_in;
         last_poll_ff  <= last_poll_in;
         request_ms_ff <= request_ms_in;
         org_sec_ff    <= org_sec_in;
         org_us_ff     <= org_us_in;
      end
   end

endmodule

@@ sv/ntppoc_back.sv @@
module ntppoc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  ntppoc_pkg::cfg_type   cfg,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  ntppoc_pkg::entry_type in_entry,
   output logic                  out_valid,
   input  logic                  out_ready,
   output ntppoc_pkg::rsp_type   out_rsp
);
   import ntppoc_pkg::*;

   typedef struct packed {
      ctl_type          ctl;
      logic [31:0]      lsec;
      logic [31:0]      nsec_cur;
      logic [31:0]      nsec_org;
      logic [2:0][31:0] prod_cur;
      logic [2:0][31:0] prod_org;
      logic [31:0]      t2s;
      logic [31:0]      t2f;
      logic [31:0]      t3s;
      logic [31:0]      t3f;
   } s1_type;

   typedef struct packed {
      ctl_type     ctl;
      logic [31:0] lsec;
      logic [31:0] nsec_cur;
      logic [31:0] nsec_org;
      logic [31:0] frac_cur;
      logic [31:0] frac_org;
      logic [31:0] t2s;
      logic [31:0] t2f;
      logic [31:0] t3s;
      logic [31:0] t3f;
   } s2_type;

   typedef struct packed {
      ctl_type     ctl;
      logic [31:0] lsec;
      logic [31:0] nsec_cur;
      logic [31:0] frac_cur;
      logic [31:0] ds1;
      logic [31:0] ds2;
      logic [31:0] fd1;
      logic [31:0] fd2;
   } s3_type;

   typedef struct packed {
      ctl_type     ctl;
      logic [31:0] lsec;
      logic [31:0] nsec_cur;
      logic [31:0] frac_cur;
      logic [31:0] os_raw;
      logic [19:0] dus1;
      logic [19:0] dus2;
      logic [19:0] cur_us;
   } s4_type;

   typedef struct packed {
      ctl_type     ctl;
      logic [31:0] lsec;
      logic [31:0] nsec_cur;
      logic [31:0] frac_cur;
      logic [31:0] hs;
      logic [19:0] hus;
      logic [19:0] cur_us;
   } s5_type;

   logic        adv;
   logic [4:0]  valid_ff, valid_in;
   logic        out_valid_ff;
   rsp_type     rsp_ff, rsp_in;
   s1_type      s1_ff, s1_in;
   s2_type      s2_ff, s2_in;
   s3_type      s3_ff, s3_in;
   s4_type      s4_ff, s4_in;
   s5_type      s5_ff, s5_in;

   logic [31:0] utc32;
   logic [20:0] ous, ousn, nus, nusn;
   logic        ous_carry, nus_carry;
   logic [31:0] os;

   assign adv       = !out_valid_ff || out_ready;
   assign in_ready  = adv;
   assign valid_in  = {valid_ff[3:0], in_valid};
   assign out_valid = out_valid_ff;
   assign out_rsp   = rsp_ff;
   assign utc32     = {{15{cfg.utc_offset_seconds[16]}}, cfg.utc_offset_seconds};

   // local clock to ntp seconds, fraction products
   always_comb begin
      s1_in.ctl         = in_entry.ctl;
      s1_in.lsec        = in_entry.local_seconds;
      s1_in.nsec_cur    = in_entry.local_seconds - utc32 + EPOCH_GAP;
      s1_in.nsec_org    = in_entry.org_seconds;
      s1_in.prod_cur[0] = 32'(in_entry.local_micros) * M2F_MUL_A;
      s1_in.prod_cur[1] = 32'(in_entry.local_micros) * M2F_MUL_B;
      s1_in.prod_cur[2] = 32'(in_entry.local_micros) * M2F_MUL_C;
      s1_in.prod_org[0] = 32'(in_entry.org_micros) * M2F_MUL_A;
      s1_in.prod_org[1] = 32'(in_entry.org_micros) * M2F_MUL_B;
      s1_in.prod_org[2] = 32'(in_entry.org_micros) * M2F_MUL_C;
      s1_in.t2s         = in_entry.recv_seconds;
      s1_in.t2f         = in_entry.recv_fraction;
      s1_in.t3s         = in_entry.xmit_seconds;
      s1_in.t3f         = in_entry.xmit_fraction;
   end

   always_comb begin
      s2_in.ctl      = s1_ff.ctl;
      s2_in.lsec     = s1_ff.lsec;
      s2_in.nsec_cur = s1_ff.nsec_cur;
      s2_in.nsec_org = s1_ff.nsec_org;
      s2_in.frac_cur = s1_ff.prod_cur[0] + (s1_ff.prod_cur[1] >> M2F_SHIFT_B)
                       + (s1_ff.prod_cur[2] >> M2F_SHIFT_C);
      s2_in.frac_org = s1_ff.prod_org[0] + (s1_ff.prod_org[1] >> M2F_SHIFT_B)
                       + (s1_ff.prod_org[2] >> M2F_SHIFT_C);
      s2_in.t2s      = s1_ff.t2s;
      s2_in.t2f      = s1_ff.t2f;
      s2_in.t3s      = s1_ff.t3s;
      s2_in.t3f      = s1_ff.t3f;
   end

   // timestamp differences with borrow
   always_comb begin
      s3_in.ctl      = s2_ff.ctl;
      s3_in.lsec     = s2_ff.lsec;
      s3_in.nsec_cur = s2_ff.nsec_cur;
      s3_in.frac_cur = s2_ff.frac_cur;
      s3_in.ds1      = s2_ff.t2s - s2_ff.nsec_org - 32'(s2_ff.t2f < s2_ff.frac_org);
      s3_in.ds2      = s2_ff.t3s - s2_ff.nsec_cur - 32'(s2_ff.t3f < s2_ff.frac_cur);
      s3_in.fd1      = s2_ff.t2f - s2_ff.frac_org;
      s3_in.fd2      = s2_ff.t3f - s2_ff.frac_cur;
   end

   always_comb begin
      s4_in.ctl      = s3_ff.ctl;
      s4_in.lsec     = s3_ff.lsec;
      s4_in.nsec_cur = s3_ff.nsec_cur;
      s4_in.frac_cur = s3_ff.frac_cur;
      s4_in.os_raw   = s3_ff.ds1 + s3_ff.ds2;
      s4_in.dus1     = frac_to_micros(s3_ff.fd1);
      s4_in.dus2     = frac_to_micros(s3_ff.fd2);
      s4_in.cur_us   = frac_to_micros(s3_ff.frac_cur);
   end

   // normalize and halve the offset
   always_comb begin
      ous            = {1'b0, s4_ff.dus1} + {1'b0, s4_ff.dus2};
      ous_carry      = (ous >= ONE_MILLION);
      ousn           = ous_carry ? ous - ONE_MILLION : ous;
      os             = s4_ff.os_raw + 32'(ous_carry);
      s5_in.ctl      = s4_ff.ctl;
      s5_in.lsec     = s4_ff.lsec;
      s5_in.nsec_cur = s4_ff.nsec_cur;
      s5_in.frac_cur = s4_ff.frac_cur;
      s5_in.hs       = {os[31], os[31:1]};
      s5_in.hus      = ousn[20:1] + (os[0] ? HALF_MILLION : 20'd0);
      s5_in.cur_us   = s4_ff.cur_us;
   end

   // corrected clock and result word
   always_comb begin
      nus       = {1'b0, s5_ff.cur_us} + {1'b0, s5_ff.hus};
      nus_carry = (nus >= ONE_MILLION);
      nusn      = nus_carry ? nus - ONE_MILLION : nus;
      rsp_in    = '0;
      rsp_in.status = s5_ff.ctl.status;
      if (s5_ff.ctl.send_request) begin
         rsp_in.send_request    = 1'b1;
         rsp_in.origin_seconds  = s5_ff.nsec_cur;
         rsp_in.origin_fraction = s5_ff.frac_cur;
      end
      if (s5_ff.ctl.set_clock) begin
         rsp_in.set_clock      = 1'b1;
         rsp_in.new_seconds    = s5_ff.lsec + s5_ff.hs + 32'(nus_carry);
         rsp_in.new_micros     = nusn[19:0];
         rsp_in.offset_seconds = s5_ff.hs;
         rsp_in.offset_micros  = s5_ff.hus;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff     <= valid_in;
         out_valid_ff <= valid_ff[4];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         s4_ff  <= s4_in;
         s5_ff  <= s5_in;
         rsp_ff <= rsp_in;
      end
   end

endmodule

@@ sv/ntp_poll_and_clock_offset_core.sv @@
// SNTP client poll sequencer with clock offset calculation. Every req word (a tick or a
// received reply) yields exactly one rsp word holding the status after that word, plus,
// where one is due, either a request with its originate timestamp or the corrected local
// clock and the offset. One req word is taken per cycle while req_ready is high; each
// result is computed by the six-register compute pipeline that follows the poll/timeout
// decision logic. A queue of QUEUE_DEPTH words sits between the decision logic and the
// pipeline; while rsp_valid is high and rsp_ready is low the pipeline holds and
// req_ready drops once that queue fills. server_addr zero disables the client. csr
// writes are taken on every cycle and must only be issued while no word is in flight.
module ntp_poll_and_clock_offset_core #(
   parameter int QUEUE_DEPTH = ntppoc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  ntppoc_pkg::req_type                req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output ntppoc_pkg::rsp_type                rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ntppoc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                        csr_data
);
   import ntppoc_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      push_valid, push_ready;
   entry_type push_entry;
   logic      pop_valid, pop_ready;
   entry_type pop_entry;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SERVER_ADDR:   cfg_in.server_addr        = csr_data;
            CSR_UTC_OFFSET:    cfg_in.utc_offset_seconds = csr_data[16:0];
            CSR_POLL_INTERVAL: cfg_in.poll_interval_ms   = csr_data;
            CSR_TIMEOUT:       cfg_in.timeout_ms         = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.server_addr        <= '0;
         cfg_ff.utc_offset_seconds <= '0;
         cfg_ff.poll_interval_ms   <= POLL_INTERVAL_RST;
         cfg_ff.timeout_ms         <= TIMEOUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ntppoc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   ntppoc_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (push_valid),
      .wr_ready (push_ready),
      .wr_data  (push_entry),
      .rd_valid (pop_valid),
      .rd_ready (pop_ready),
      .rd_data  (pop_entry)
   );

   ntppoc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (pop_valid),
      .in_ready  (pop_ready),
      .in_entry  (pop_entry),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_rsp   (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_micros_normalized: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.set_clock |->
         ({1'b0, rsp_data.new_micros} < ONE_MILLION)
         && ({1'b0, rsp_data.offset_micros} < ONE_MILLION))
      else $error("corrected or offset micros not below one million");

   a_request_xor_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.send_request && rsp_data.set_clock))
      else $error("request and clock set in the same word");

   a_request_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.send_request |-> rsp_data.status == ST_WAITING)
      else $error("request sent without waiting status");

   a_set_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.set_clock |-> rsp_data.status == ST_IDLE)
      else $error("clock set without returning to idle");
`endif

endmodule
